@@ rtl/core/cau_pkg.sv @@
// ----------------------------------------------------------------------------
// cau_pkg
// Types and constants shared by the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

    localparam int PART_WIDTH = 16;

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2,
        CMD_DIV = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_SAT = 2'd1,
        ST_DZ  = 2'd2
    } t_status;

    typedef struct packed {
        t_cmd                          cmd;
        logic signed [PART_WIDTH-1:0]  lhs_real;
        logic signed [PART_WIDTH-1:0]  lhs_imag;
        logic signed [PART_WIDTH-1:0]  rhs_real;
        logic signed [PART_WIDTH-1:0]  rhs_imag;
    } t_in_beat;

    typedef struct packed {
        logic signed [PART_WIDTH-1:0]  res_real;
        logic signed [PART_WIDTH-1:0]  res_imag;
        t_status                       status;
    } t_out_beat;

endpackage

@@ rtl/core/complex_arith_unit_top.sv @@
// ----------------------------------------------------------------------------
// complex_arith_unit_top
// Complex add, subtract, multiply and divide on signed fixed-point parts.
//
// A beat is offered on i_beat with start; it is taken whenever start is high
// and busy is low. Busy is always low, so one beat can enter every cycle.
// Each beat gives exactly one result on o_beat, marked by o_valid for one
// cycle. Throughput is one beat per cycle for every operation. The divider
// resolves one quotient bit per pipeline stage for the real and imaginary
// parts in parallel and so sets the depth of the pipeline; all operations
// share that pipeline so results leave in order. Multiply and divide
// truncate toward zero, results saturate with status saturated, and a zero
// divisor gives a zero result with status divide by zero. The receiver
// cannot hold results off, so there is no stall. Reset clears only the
// valid bits of the pipeline.
// ----------------------------------------------------------------------------
module complex_arith_unit_top #(
    parameter int FRAC_BITS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  cau_pkg::t_in_beat    i_beat,
    output logic                 o_valid,
    output cau_pkg::t_out_beat   o_beat
);

    localparam int W  = cau_pkg::PART_WIDTH;
    localparam int SW = 2 * W + 1;
    localparam int DW = 3 * W + FRAC_BITS + 2;
    localparam int QW = W + 1;
    localparam int NS = W + 1;
    localparam logic [QW-1:0] CAP = QW'((1 << (W - 1)) + 1);

    typedef struct packed {
        logic                   vld;
        cau_pkg::t_cmd          cmd;
        logic signed [W-1:0]    ar;
        logic signed [W-1:0]    ai;
        logic signed [W-1:0]    br;
        logic signed [W-1:0]    bi;
        logic signed [2*W-1:0]  p_rr;
        logic signed [2*W-1:0]  p_ii;
        logic signed [2*W-1:0]  p_ri;
        logic signed [2*W-1:0]  p_ir;
        logic signed [2*W-1:0]  p_br2;
        logic signed [2*W-1:0]  p_bi2;
    } t_s1;

    typedef struct packed {
        logic                   vld;
        cau_pkg::t_cmd          cmd;
        logic signed [SW-1:0]   sr;
        logic signed [SW-1:0]   si;
        logic [2*W-1:0]         den;
    } t_s2;

    typedef struct packed {
        logic                   vld;
        cau_pkg::t_cmd          cmd;
        logic                   neg_r;
        logic                   neg_i;
        logic [SW-1:0]          mag_r;
        logic [SW-1:0]          mag_i;
        logic [2*W-1:0]         den;
    } t_s3;

    typedef struct packed {
        logic                   vld;
        logic                   is_div;
        logic                   dz;
        logic                   neg_r;
        logic                   neg_i;
        logic [2*W-1:0]         den;
        logic [DW-1:0]          rem_r;
        logic [DW-1:0]          rem_i;
        logic [QW-1:0]          q_r;
        logic [QW-1:0]          q_i;
        logic                   ovf_r;
        logic                   ovf_i;
    } t_dv;

    t_s1  r_s1, n_s1;
    t_s2  r_s2, n_s2;
    t_s3  r_s3, n_s3;
    t_dv  r_dv [0:NS];
    t_dv  n_dv0;
    logic r_out_vld;
    cau_pkg::t_out_beat r_out, n_out;

    function automatic logic [W:0] pack_part(input logic neg, input logic [QW-1:0] mag);
        logic [W-1:0] v;
        logic         s;
        begin
            s = 1'b0;
            if (!neg) begin
                if (mag > QW'((1 << (W - 1)) - 1)) begin
                    s = 1'b1;
                    v = W'((1 << (W - 1)) - 1);
                end else begin
                    v = mag[W-1:0];
                end
            end else begin
                if (mag > QW'(1 << (W - 1))) begin
                    s = 1'b1;
                    v = W'(1 << (W - 1));
                end else begin
                    v = W'(~mag + 1'b1);
                end
            end
            pack_part = {s, v};
        end
    endfunction

    assign busy = 1'b0;

    always_comb begin
        n_s1       = r_s1;
        n_s1.vld   = start && !busy;
        n_s1.cmd   = i_beat.cmd;
        n_s1.ar    = i_beat.lhs_real;
        n_s1.ai    = i_beat.lhs_imag;
        n_s1.br    = i_beat.rhs_real;
        n_s1.bi    = i_beat.rhs_imag;
        n_s1.p_rr  = i_beat.lhs_real * i_beat.rhs_real;
        n_s1.p_ii  = i_beat.lhs_imag * i_beat.rhs_imag;
        n_s1.p_ri  = i_beat.lhs_real * i_beat.rhs_imag;
        n_s1.p_ir  = i_beat.lhs_imag * i_beat.rhs_real;
        n_s1.p_br2 = i_beat.rhs_real * i_beat.rhs_real;
        n_s1.p_bi2 = i_beat.rhs_imag * i_beat.rhs_imag;
    end

    always_comb begin
        n_s2     = r_s2;
        n_s2.vld = r_s1.vld;
        n_s2.cmd = r_s1.cmd;
        n_s2.den = $unsigned(r_s1.p_br2) + $unsigned(r_s1.p_bi2);
        case (r_s1.cmd)
            cau_pkg::CMD_ADD: begin
                n_s2.sr = SW'($signed(r_s1.ar)) + SW'($signed(r_s1.br));
                n_s2.si = SW'($signed(r_s1.ai)) + SW'($signed(r_s1.bi));
            end
            cau_pkg::CMD_SUB: begin
                n_s2.sr = SW'($signed(r_s1.ar)) - SW'($signed(r_s1.br));
                n_s2.si = SW'($signed(r_s1.ai)) - SW'($signed(r_s1.bi));
            end
            cau_pkg::CMD_MUL: begin
                n_s2.sr = SW'($signed(r_s1.p_rr)) - SW'($signed(r_s1.p_ii));
                n_s2.si = SW'($signed(r_s1.p_ri)) + SW'($signed(r_s1.p_ir));
            end
            default: begin
                n_s2.sr = SW'($signed(r_s1.p_rr)) + SW'($signed(r_s1.p_ii));
                n_s2.si = SW'($signed(r_s1.p_ir)) - SW'($signed(r_s1.p_ri));
            end
        endcase
    end

    always_comb begin
        n_s3       = r_s3;
        n_s3.vld   = r_s2.vld;
        n_s3.cmd   = r_s2.cmd;
        n_s3.den   = r_s2.den;
        n_s3.neg_r = r_s2.sr[SW-1];
        n_s3.neg_i = r_s2.si[SW-1];
        n_s3.mag_r = r_s2.sr[SW-1] ? SW'(-r_s2.sr) : SW'(r_s2.sr);
        n_s3.mag_i = r_s2.si[SW-1] ? SW'(-r_s2.si) : SW'(r_s2.si);
        if (r_s2.cmd == cau_pkg::CMD_MUL) begin
            n_s3.mag_r = n_s3.mag_r >> FRAC_BITS;
            n_s3.mag_i = n_s3.mag_i >> FRAC_BITS;
        end
    end

    always_comb begin
        n_dv0        = r_dv[0];
        n_dv0.vld    = r_s3.vld;
        n_dv0.is_div = (r_s3.cmd == cau_pkg::CMD_DIV);
        n_dv0.dz     = (r_s3.den == '0);
        n_dv0.neg_r  = r_s3.neg_r;
        n_dv0.neg_i  = r_s3.neg_i;
        n_dv0.den    = r_s3.den;
        n_dv0.rem_r  = DW'(r_s3.mag_r) << FRAC_BITS;
        n_dv0.rem_i  = DW'(r_s3.mag_i) << FRAC_BITS;
        n_dv0.ovf_r  = 1'b0;
        n_dv0.ovf_i  = 1'b0;
        if (n_dv0.is_div) begin
            n_dv0.q_r   = '0;
            n_dv0.q_i   = '0;
            n_dv0.ovf_r = n_dv0.rem_r >= (DW'(r_s3.den) << QW);
            n_dv0.ovf_i = n_dv0.rem_i >= (DW'(r_s3.den) << QW);
        end else begin
            n_dv0.q_r = (r_s3.mag_r > SW'(CAP)) ? CAP : r_s3.mag_r[QW-1:0];
            n_dv0.q_i = (r_s3.mag_i > SW'(CAP)) ? CAP : r_s3.mag_i[QW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.vld    <= 1'b0;
            r_s2.vld    <= 1'b0;
            r_s3.vld    <= 1'b0;
            r_dv[0].vld <= 1'b0;
        end else begin
            r_s1    <= n_s1;
            r_s2    <= n_s2;
            r_s3    <= n_s3;
            r_dv[0] <= n_dv0;
        end
    end

    for (genvar k = 1; k <= NS; k++) begin : g_div
        localparam int J = NS - k;
        t_dv           n_dv;
        logic [DW-1:0] trial;

        always_comb begin
            n_dv  = r_dv[k-1];
            trial = DW'(r_dv[k-1].den) << J;
            if (r_dv[k-1].is_div && !r_dv[k-1].ovf_r && r_dv[k-1].rem_r >= trial) begin
                n_dv.rem_r  = r_dv[k-1].rem_r - trial;
                n_dv.q_r[J] = 1'b1;
            end
            if (r_dv[k-1].is_div && !r_dv[k-1].ovf_i && r_dv[k-1].rem_i >= trial) begin
                n_dv.rem_i  = r_dv[k-1].rem_i - trial;
                n_dv.q_i[J] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[k].vld <= 1'b0;
            end else begin
                r_dv[k] <= n_dv;
            end
        end
    end

    always_comb begin
        logic [W:0] pr;
        logic [W:0] pi;
        pr = pack_part(r_dv[NS].neg_r, r_dv[NS].ovf_r ? CAP : r_dv[NS].q_r);
        pi = pack_part(r_dv[NS].neg_i, r_dv[NS].ovf_i ? CAP : r_dv[NS].q_i);
        n_out.res_real = $signed(pr[W-1:0]);
        n_out.res_imag = $signed(pi[W-1:0]);
        n_out.status   = (pr[W] || pi[W]) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
        if (r_dv[NS].is_div && r_dv[NS].dz) begin
            n_out.res_real = '0;
            n_out.res_imag = '0;
            n_out.status   = cau_pkg::ST_DZ;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_dv[NS].vld;
        end
    end

    assign o_valid = r_out_vld;
    assign o_beat  = r_out;

endmodule
